// ===== rtl/mmt_pkg.sv =====
`timescale 1ns / 1ps

package mmt_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 16;

  localparam int ACTION_W   = 2;
  localparam int POS_W      = 6;
  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 40;
  localparam int OIDX_W     = 3;
  localparam int DIM_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ROWS  = 3'd0,
    REG_A_COLS  = 3'd1,
    REG_B_ROWS  = 3'd2,
    REG_B_COLS  = 3'd3,
    REG_A_TRANS = 3'd4,
    REG_B_TRANS = 3'd5
  } cfg_reg_e;

endpackage

// ===== rtl/mmt_ram.sv =====
`timescale 1ns / 1ps

module mmt_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/matrix_multiply_transpose_modes_core.sv =====
`timescale 1ns / 1ps
// Channel | Handshake             | Word
// --------+-----------------------+-------------------------------------------
// in      | in_valid_i/in_stall_o | action, position, element
// out     | out_valid_o/out_stall_i| product, out_row, out_col, last, error
// cfg     | cfg_we_i              | cfg_index_i, cfg_data_i (no read-back)
//
// Loads are accepted while the core is idle. The pace of a compute is set by
// the single shared multiply-accumulate and the registered read of both
// stores; a dimension mismatch goes straight to a single error word.
// in_stall_o is high for the whole of a compute. Reset clears control and
// configuration registers only; datapath registers and the stores hold no defined value until written.

module matrix_multiply_transpose_modes_core #(
  parameter int MAX_DIM    = mmt_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = mmt_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [mmt_pkg::ACTION_W-1:0]          in_action_i,
  input  logic [mmt_pkg::POS_W-1:0]             in_position_i,
  input  logic signed [mmt_pkg::ELEM_W-1:0]     in_element_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [mmt_pkg::PROD_W-1:0]     out_product_o,
  output logic [mmt_pkg::OIDX_W-1:0]            out_row_o,
  output logic [mmt_pkg::OIDX_W-1:0]            out_col_o,
  output logic                                  out_last_o,
  output logic                                  out_error_o,
  input  logic                                  cfg_we_i,
  input  logic [mmt_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mmt_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  import mmt_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIMV_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = POS_W + 2;
  localparam int MUL_W  = 2 * DATA_WIDTH;
  localparam int ACC_W  = MUL_W + $clog2(MAX_DIM) + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  function automatic logic [DIMV_W-1:0] dim_of(input logic [DIM_W-1:0] r);
    logic [DIM_W-1:0] v;
    v = r;
    if (v == '0) v = DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) v = DIM_W'(MAX_DIM);
    return DIMV_W'(v);
  endfunction

  // configuration
  logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic             a_trans_q, b_trans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q  <= DIM_W'(1);
      a_cols_q  <= DIM_W'(1);
      b_rows_q  <= DIM_W'(1);
      b_cols_q  <= DIM_W'(1);
      a_trans_q <= 1'b0;
      b_trans_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_A_ROWS:  a_rows_q  <= cfg_data_i;
        REG_A_COLS:  a_cols_q  <= cfg_data_i;
        REG_B_ROWS:  b_rows_q  <= cfg_data_i;
        REG_B_COLS:  b_cols_q  <= cfg_data_i;
        REG_A_TRANS: a_trans_q <= cfg_data_i[0];
        REG_B_TRANS: b_trans_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [DIMV_W-1:0] ar, ac, br, bc, m_dim, n_dim, inner_a, inner_b;

  assign ar      = dim_of(a_rows_q);
  assign ac      = dim_of(a_cols_q);
  assign br      = dim_of(b_rows_q);
  assign bc      = dim_of(b_cols_q);
  assign m_dim   = a_trans_q ? ac : ar;
  assign inner_a = a_trans_q ? ar : ac;
  assign inner_b = b_trans_q ? bc : br;
  assign n_dim   = b_trans_q ? br : bc;

  // sequencer and datapath registers
  state_e            state_q, state_d;
  logic [IDX_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic              err_q, err_d;
  logic              rd_v_q, rd_v_d, mul_v_q;
  logic              out_valid_q, out_valid_d, out_load;
  logic signed [MUL_W-1:0]  mul_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     acc_clr;
  logic signed [PROD_W-1:0] acc_sat;
  logic signed [PROD_W-1:0] out_product_q;
  logic [OIDX_W-1:0]        out_row_q, out_col_q;
  logic                     out_last_q, out_error_q;

  logic in_accept, out_free, last_k, last_j, last_elem;
  logic a_we, b_we;
  logic [ADDR_W-1:0] a_raddr, b_raddr;
  logic [DATA_WIDTH-1:0] a_rdata, b_rdata, wdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign last_k    = (DIMV_W'(k_q) + DIMV_W'(1)) == inner_a;
  assign last_j    = (DIMV_W'(j_q) + DIMV_W'(1)) == n_dim;
  assign last_elem = last_j && ((DIMV_W'(i_q) + DIMV_W'(1)) == m_dim);

  // loads
  assign wdata = DATA_WIDTH'(in_element_i);
  assign a_we  = in_accept && (in_action_i == ACT_LOAD_A) &&
                 (CMP_W'(in_position_i) < CMP_W'(ar) * CMP_W'(ac));
  assign b_we  = in_accept && (in_action_i == ACT_LOAD_B) &&
                 (CMP_W'(in_position_i) < CMP_W'(br) * CMP_W'(bc));

  assign a_raddr = a_trans_q ?
                   ADDR_W'(ADDR_W'(k_q) * ADDR_W'(ac) + ADDR_W'(i_q)) :
                   ADDR_W'(ADDR_W'(i_q) * ADDR_W'(ac) + ADDR_W'(k_q));
  assign b_raddr = b_trans_q ?
                   ADDR_W'(ADDR_W'(j_q) * ADDR_W'(bc) + ADDR_W'(k_q)) :
                   ADDR_W'(ADDR_W'(k_q) * ADDR_W'(bc) + ADDR_W'(j_q));

  mmt_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_a_store (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (in_position_i[ADDR_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mmt_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_b_store (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (in_position_i[ADDR_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    err_d    = err_q;
    rd_v_d   = 1'b0;
    acc_clr  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept && (in_action_i == ACT_COMPUTE)) begin
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          acc_clr = 1'b1;
          err_d   = (inner_a != inner_b);
          state_d = (inner_a != inner_b) ? S_EMIT : S_ISSUE;
        end
      end
      S_ISSUE: begin
        rd_v_d = 1'b1;
        if (last_k) begin
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (!rd_v_q && !mul_v_q) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (err_q || last_elem) begin
            state_d = S_IDLE;
          end else begin
            acc_clr = 1'b1;
            k_d     = '0;
            state_d = S_ISSUE;
            if (last_j) begin
              j_d = '0;
              i_d = i_q + IDX_W'(1);
            end else begin
              j_d = j_q + IDX_W'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      err_q       <= 1'b0;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      err_q       <= err_d;
      rd_v_q      <= rd_v_d;
      mul_v_q     <= rd_v_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= $signed(a_rdata) * $signed(b_rdata);
    if (acc_clr) begin
      acc_q <= '0;
    end else if (mul_v_q) begin
      acc_q <= acc_q + ACC_W'(mul_q);
    end
    if (out_load) begin
      out_product_q <= err_q ? '0 : acc_sat;
      out_row_q     <= err_q ? '0 : OIDX_W'(i_q);
      out_col_q     <= err_q ? '0 : OIDX_W'(j_q);
      out_last_q    <= err_q || last_elem;
      out_error_q   <= err_q;
    end
  end

  generate
    if (ACC_W > PROD_W) begin : g_sat
      logic ovf;
      assign ovf = !(&acc_q[ACC_W-1:PROD_W-1]) && (|acc_q[ACC_W-1:PROD_W-1]);
      assign acc_sat = !ovf ? acc_q[PROD_W-1:0] :
                       acc_q[ACC_W-1] ? {1'b1, {(PROD_W-1){1'b0}}} :
                                        {1'b0, {(PROD_W-1){1'b1}}};
    end else begin : g_ext
      assign acc_sat = PROD_W'(acc_q);
    end
  endgenerate

  assign out_valid_o   = out_valid_q;
  assign out_product_o = out_product_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign out_last_o    = out_last_q;
  assign out_error_o   = out_error_q;

  a_mac_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_v_q |-> (state_q == S_ISSUE || state_q == S_DRAIN))
    else $error("accumulate outside a compute run");

  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (!rd_v_q && !mul_v_q))
    else $error("result taken before pipeline drained");

  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("output word loaded outside emit");

  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_error_q) |-> (out_last_q && out_product_q == '0))
    else $error("error word malformed");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_v_q || mul_v_q) |-> in_stall_o)
    else $error("input open while multiply in flight");

endmodule
